FILE: rtl/gcd_lcm_unit_assert.svh
// Assertion macros for the GCD/LCM unit.
// Included by gcd_lcm_unit, which carries the concurrent checks; no other dependencies.
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checks that an implication holds in the same cycle.
`define GCLU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Checks that an implication holds in the next cycle.
`define GCLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GCLU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define GCLU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/gclu_pkg.sv
// Shared constants and types for the GCD/LCM unit.
// Used by gclu_div and gcd_lcm_unit; depends on nothing else.
package gclu_pkg;

	// Operand and result width.
	localparam int WIDTH = 31;
	// Bits of the divider step counter.
	localparam int CNT_W = $clog2(WIDTH);
	// Largest value that a result can hold.
	localparam logic [WIDTH-1:0] MAXV = {WIDTH{1'b1}};
	// Stream data widths, padded to whole bytes.
	localparam int IN_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * WIDTH + 1 + 7) / 8) * 8;

	// Request from the sequencer to the shared divider.
	typedef struct packed {
		logic             start;
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
	} div_req_t;

	// Answer from the shared divider.
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [WIDTH-1:0] quotient;
		logic [WIDTH-1:0] remainder;
	} div_resp_t;

endpackage

FILE: rtl/gclu_div.sv
// Shared restoring divider of the GCD/LCM unit, one quotient bit per cycle.
// Depends on gclu_pkg for the width and the request and answer structs.
module gclu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  gclu_pkg::div_req_t  req,
	output gclu_pkg::div_resp_t resp
);
	import gclu_pkg::*;

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   rem_sh;
	logic             ge;
	logic [WIDTH:0]   rem_diff;
	logic [WIDTH-1:0] rem_nxt;

	// One restoring step: shift in the next dividend bit, subtract when it fits.
	always_comb begin
		rem_sh   = {rem_q, quo_q[WIDTH-1]};
		ge       = (rem_sh >= {1'b0, dvs_q});
		rem_diff = rem_sh - {1'b0, dvs_q};
		rem_nxt  = ge ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
	end

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Partial remainder and quotient, the dividend shifting out as quotient bits enter.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[WIDTH-2:0], ge};
		end
	end

	assign resp.busy      = busy_q;
	assign resp.done      = done_q;
	assign resp.quotient  = quo_q;
	assign resp.remainder = rem_q;

endmodule

FILE: rtl/gcd_lcm_unit.sv
// GCD/LCM unit: takes two 31-bit unsigned operands and returns their greatest common
// divisor (Euclid's repeated remainder) and least common multiple, (a / gcd) * b,
// saturated to all ones with an overflow flag when it does not fit in 31 bits. One
// item is worked on at a time and s_tready is low meanwhile. Each remainder step of
// Euclid is one division on the shared one-bit-per-cycle divider, and a 31-bit pair
// needs at most about 45 such steps; the lcm then takes one more division, one
// multiply and one load of the result register. A result waiting in the output
// register does not block the next input transfer; only the final load waits for it.
// Depends on gclu_pkg, gclu_div and gcd_lcm_unit_assert.svh.
`include "gcd_lcm_unit_assert.svh"

module gcd_lcm_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Fields from bit 0: operand_a[30:0], operand_b[61:31], zero padding.
	input  logic [gclu_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// Fields from bit 0: gcd_value[30:0], lcm_value[61:31], lcm_overflow[62], padding.
	output logic [gclu_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready
);
	import gclu_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TEST = 6'b000010,
		ST_REM  = 6'b000100,
		ST_QUOT = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t             state_q;
	logic [WIDTH-1:0]   a_q;
	logic [WIDTH-1:0]   b_q;
	logic [WIDTH-1:0]   x_q;
	logic [WIDTH-1:0]   y_q;
	logic               turn_q;
	logic [WIDTH-1:0]   g_q;
	logic [WIDTH-1:0]   q_q;
	logic [2*WIDTH-1:0] prod_q;
	logic [WIDTH-1:0]   gcd_q;
	logic [WIDTH-1:0]   lcm_q;
	logic               ovf_q;
	logic               m_tvalid_q;

	div_req_t           div_req;
	div_resp_t          div_resp;

	logic               in_xfer;
	logic               out_free;
	logic [WIDTH-1:0]   dvd;
	logic [WIDTH-1:0]   dvs;
	logic               prod_ovf;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// The pair alternates roles: first y %= x, then x %= y.
	assign dvd      = turn_q ? x_q : y_q;
	assign dvs      = turn_q ? y_q : x_q;
	assign prod_ovf = (prod_q > {{WIDTH{1'b0}}, MAXV});

	// Requests to the shared divider: a remainder step, or a / gcd for the lcm.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = dvd;
		div_req.divisor  = dvs;
		if (state_q == ST_TEST && dvs != '0) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_REM && div_resp.done && div_resp.remainder == '0
				&& g_q == '0) begin
			div_req.start = 1'b0;
		end
		if (state_q == ST_TEST && dvs == '0 && dvd != '0) begin
			div_req.start    = 1'b1;
			div_req.dividend = a_q;
			div_req.divisor  = dvd;
		end
	end

	gclu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_TEST;
					end
				end
				ST_TEST: begin
					if (dvs != '0) begin
						state_q <= ST_REM;
					end else if (dvd != '0) begin
						state_q <= ST_QUOT;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_REM: begin
					if (div_resp.done) begin
						state_q <= ST_TEST;
					end
				end
				ST_QUOT: begin
					if (div_resp.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the Euclid loop and the lcm.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					a_q    <= s_tdata[WIDTH-1:0];
					b_q    <= s_tdata[2*WIDTH-1:WIDTH];
					x_q    <= s_tdata[WIDTH-1:0];
					y_q    <= s_tdata[2*WIDTH-1:WIDTH];
					turn_q <= 1'b0;
				end
			end
			ST_TEST: begin
				if (dvs == '0) begin
					g_q <= dvd;
					q_q <= '0;
				end
			end
			ST_REM: begin
				if (div_resp.done) begin
					if (turn_q) begin
						x_q <= div_resp.remainder;
					end else begin
						y_q <= div_resp.remainder;
					end
					turn_q <= !turn_q;
				end
			end
			ST_QUOT: begin
				if (div_resp.done) begin
					q_q <= div_resp.quotient;
				end
			end
			ST_MUL: begin
				prod_q <= (2*WIDTH)'(q_q) * (2*WIDTH)'(b_q);
			end
			default: begin
			end
		endcase
	end

	// Output register, loaded once the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			gcd_q <= g_q;
			lcm_q <= prod_ovf ? MAXV : prod_q[WIDTH-1:0];
			ovf_q <= prod_ovf;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2 * WIDTH - 1){1'b0}}, ovf_q, lcm_q, gcd_q};

	// The divider works only while the sequencer waits on it.
	`GCLU_ASSERT_SAME(a_div_idle, clk, arst_n, div_resp.busy,
		(state_q == ST_REM) || (state_q == ST_QUOT), "divider busy outside a wait state")
	// A finished division is always consumed by a waiting state.
	`GCLU_ASSERT_SAME(a_done_seen, clk, arst_n, div_resp.done,
		(state_q == ST_REM) || (state_q == ST_QUOT), "division result not consumed")
	// An input transfer always starts the Euclid loop.
	`GCLU_ASSERT_NEXT(a_start_loop, clk, arst_n, in_xfer,
		(state_q == ST_TEST) && !turn_q, "input transfer did not start the loop")
	// A division is never started by a zero divisor.
	`GCLU_ASSERT_SAME(a_div_nonzero, clk, arst_n, div_req.start,
		div_req.divisor != '0, "division started with zero divisor")

endmodule
